// ===== rtl/core/lzfd_pkg.sv =====
// shared types, constants and pointer helpers for the flagged-token lz decompressor
// no dependencies; used by lzfd_history, lzfd_parser and the top level
`default_nettype none

package lzfd_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int PTR_W        = ADDR_W + 1;
    localparam int DIST_W       = 10;
    localparam int COUNT_W      = 6;
    localparam int LITS_W       = 7;
    localparam int TOKENS_W     = 4;

    localparam logic [7:0]          CMD_END          = 8'hFF;
    localparam logic [7:0]          LIT_RUN_BIAS     = 8'hB8;
    localparam logic [TOKENS_W-1:0] FLAG_TOKENS      = 4'd8;
    localparam logic [COUNT_W-1:0]  SHORT_COPY_BIAS  = 6'd6;
    localparam logic [COUNT_W-1:0]  LONG_COPY_BIAS   = 6'd3;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_LONG2,
        PH_LITRUN
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LIT,
        ACT_COPY,
        ACT_END
    } act_kind_t;

    typedef struct packed {
        act_kind_t            kind;
        logic [7:0]           data;
        logic [DIST_W-1:0]    distance;
        logic [COUNT_W-1:0]   count;
    } action_t;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] ptr);
        logic [ADDR_W-1:0] r;
        if (ptr == ADDR_W'(WINDOW_DEPTH - 1))
            r = '0;
        else
            r = ptr + 1'b1;
        return r;
    endfunction

    // ring subtract, works for any depth that is at least the largest distance
    function automatic logic [ADDR_W-1:0] ptr_back(input logic [ADDR_W-1:0] ptr,
                                                   input logic [DIST_W-1:0] distance);
        logic [PTR_W-1:0] p;
        logic [PTR_W-1:0] d;
        logic [PTR_W-1:0] s;
        p = {1'b0, ptr};
        d = PTR_W'(distance);
        if (p >= d)
            s = p - d;
        else
            s = p + PTR_W'(WINDOW_DEPTH) - d;
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lzfd_history.sv =====
// history window: single-port-write, single-port-read ram with a registered read
// forwards a same-cycle write to the read data; depends on lzfd_pkg
`default_nettype none

module lzfd_history
    import lzfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    output logic [7:0]             rdata
);

    logic [7:0] mem [WINDOW_DEPTH];
    logic [7:0] rd_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg       <= mem[raddr];
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (re)
        begin
            fwd_reg <= we && (waddr == raddr);
        end
    end

    // read data holds while re is low
    assign rdata = fwd_reg ? fwd_data_reg : rd_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lzfd_parser.sv =====
// token parser: flag byte, literal, short and long copy, literal run and end commands
// decodes each accepted byte into an action; depends on lzfd_pkg
`default_nettype none

module lzfd_parser
    import lzfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       new_stream,
    output action_t         action
);

    phase_t              phase_reg, phase_next;
    logic [7:0]          flags_reg, flags_next;
    logic [TOKENS_W-1:0] tokens_reg, tokens_next;
    logic [7:0]          held_reg, held_next;
    logic [LITS_W-1:0]   lits_reg, lits_next;
    logic                finished_reg, finished_next;

    // state as seen after an optional stream restart
    phase_t              eff_phase;
    logic [7:0]          eff_flags;
    logic [TOKENS_W-1:0] eff_tokens;
    logic [7:0]          eff_held;
    logic [LITS_W-1:0]   eff_lits;
    logic                eff_finished;
    logic                flag_bit;
    logic [LITS_W-1:0]   lits_dec;
    logic [7:0]          run_len;

    assign eff_phase    = new_stream ? PH_TOKEN : phase_reg;
    assign eff_flags    = new_stream ? 8'h00 : flags_reg;
    assign eff_tokens   = new_stream ? '0 : tokens_reg;
    assign eff_held     = new_stream ? 8'h00 : held_reg;
    assign eff_lits     = new_stream ? '0 : lits_reg;
    assign eff_finished = new_stream ? 1'b0 : finished_reg;
    assign flag_bit     = eff_flags[0];
    assign lits_dec     = (eff_lits != '0) ? eff_lits - 1'b1 : '0;
    assign run_len      = in_byte - LIT_RUN_BIAS;

    always_comb
    begin
        phase_next    = eff_phase;
        flags_next    = eff_flags;
        tokens_next   = eff_tokens;
        held_next     = eff_held;
        lits_next     = eff_lits;
        finished_next = eff_finished;
        if (!eff_finished)
        begin
            case (eff_phase)
                PH_LITRUN:
                begin
                    lits_next = lits_dec;
                    if (lits_dec == '0)
                        phase_next = PH_TOKEN;
                end
                PH_LONG2:
                begin
                    phase_next = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (eff_tokens == '0)
                    begin
                        flags_next  = in_byte;
                        tokens_next = FLAG_TOKENS;
                    end
                    else
                    begin
                        flags_next  = {1'b0, eff_flags[7:1]};
                        tokens_next = eff_tokens - 1'b1;
                        if (flag_bit)
                        begin
                            if (!in_byte[7])
                            begin
                                held_next  = in_byte;
                                phase_next = PH_LONG2;
                            end
                            else if (in_byte[6])
                            begin
                                if (in_byte == CMD_END)
                                    finished_next = 1'b1;
                                else
                                begin
                                    lits_next  = run_len[LITS_W-1:0];
                                    phase_next = PH_LITRUN;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_TOKEN;
                end
            endcase
        end
    end

    always_comb
    begin
        action.kind     = ACT_NONE;
        action.data     = in_byte;
        action.distance = {eff_held[1:0], in_byte};
        action.count    = COUNT_W'(eff_held[6:2]) + LONG_COPY_BIAS;
        if (!eff_finished)
        begin
            case (eff_phase)
                PH_LITRUN:
                begin
                    action.kind = ACT_LIT;
                end
                PH_LONG2:
                begin
                    action.kind = ACT_COPY;
                end
                PH_TOKEN:
                begin
                    if (eff_tokens != '0)
                    begin
                        if (!flag_bit)
                            action.kind = ACT_LIT;
                        else if (in_byte == CMD_END)
                        begin
                            action.kind = ACT_END;
                            action.data = 8'h00;
                        end
                        else if (in_byte[7] && !in_byte[6])
                        begin
                            // short copy: distance 1..16, length 2..5
                            action.kind     = ACT_COPY;
                            action.distance = DIST_W'(in_byte[3:0]) + 1'b1;
                            action.count    = COUNT_W'(in_byte[7:4]) - SHORT_COPY_BIAS;
                        end
                    end
                end
                default:
                begin
                    action.kind = ACT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TOKEN;
            flags_reg    <= 8'h00;
            tokens_reg   <= '0;
            held_reg     <= 8'h00;
            lits_reg     <= '0;
            finished_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            flags_reg    <= flags_next;
            tokens_reg   <= tokens_next;
            held_reg     <= held_next;
            lits_reg     <= lits_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lz_flagged_token_decompressor.sv =====
// top level of the flagged-token lz decompressor: input parser, copy engine, output register
// depends on lzfd_pkg, lzfd_parser and lzfd_history
`default_nettype none

// Takes one compressed byte per input word and emits the decompressed bytes it completes,
// one output word per cycle unless the output stalls. Flag bytes, run headers and the first
// byte of a long copy give no output; a literal gives one word and the end command a single
// word with tuser set and zero data. A byte is taken whenever no copy is in progress and the
// output register is free or being drained. During a copy of n bytes (2 to 34) the input is
// held until the last byte is written back: the history window is a 1024 x 8 ram with one
// registered read port, read once per copied byte and written back as that byte is presented
// at the output, with same-cycle forwarding for a distance of one. The ram
// has no clearing pass after reset; a copy reaching back past what was written returns
// stale window contents.
module lz_flagged_token_decompressor
    import lzfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tuser,   // [0] new_stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,
    output logic            m_axis_tuser    // [0] end_of_stream
);

    action_t             action;
    logic                in_accept;
    logic                adv;
    logic                copy_active;
    logic                issue;
    logic                drain;

    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [ADDR_W-1:0]   src_reg, src_next;
    logic [COUNT_W-1:0]  copy_left_reg, copy_left_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_last_reg, pend_last_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                out_end_reg, out_end_next;

    logic                hist_we;
    logic [7:0]          hist_wdata;
    logic [7:0]          hist_rdata;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign copy_active   = (copy_left_reg != '0) || pend_valid_reg;
    assign s_axis_tready = !copy_active && adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign issue         = adv && (copy_left_reg != '0);
    assign drain         = adv && pend_valid_reg;

    lzfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .in_byte    (s_axis_tdata),
        .new_stream (s_axis_tuser),
        .action     (action)
    );

    assign hist_we    = drain || (in_accept && action.kind == ACT_LIT);
    assign hist_wdata = drain ? hist_rdata : action.data;

    lzfd_history u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (issue),
        .raddr (src_reg),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (hist_wdata),
        .rdata (hist_rdata)
    );

    // copy engine: issue reads, then write back and present each returned byte
    always_comb
    begin
        wp_next         = hist_we ? ptr_inc(wp_reg) : wp_reg;
        src_next        = src_reg;
        copy_left_next  = copy_left_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        if (in_accept && action.kind == ACT_COPY)
        begin
            src_next       = ptr_back(wp_reg, action.distance);
            copy_left_next = action.count;
        end
        if (issue)
        begin
            src_next        = ptr_inc(src_reg);
            copy_left_next  = copy_left_reg - 1'b1;
            pend_valid_next = 1'b1;
            pend_last_next  = (copy_left_reg == COUNT_W'(1));
        end
        else if (drain)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        if (adv)
        begin
            out_valid_next = 1'b0;
            if (drain)
            begin
                out_valid_next = 1'b1;
                out_data_next  = hist_rdata;
                out_last_next  = pend_last_reg;
                out_end_next   = 1'b0;
            end
            else if (in_accept && (action.kind == ACT_LIT || action.kind == ACT_END))
            begin
                out_valid_next = 1'b1;
                out_data_next  = action.data;
                out_last_next  = 1'b1;
                out_end_next   = (action.kind == ACT_END);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            copy_left_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wp_reg         <= wp_next;
            copy_left_reg  <= copy_left_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        pend_last_reg <= pend_last_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_end_reg;

    // returned copy byte must survive an output stall
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !adv |=> pend_valid_reg && $stable(hist_rdata))
        else $error("copy read data lost during output stall");

    // the final byte of a copy closes the run
    a_copy_last: assert property (@(posedge clk) disable iff (!rst_n)
        drain && copy_left_reg == '0 |=> m_axis_tvalid && m_axis_tlast)
        else $error("final copy byte without tlast");

    // end word carries zero data and closes its run
    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
        else $error("malformed end word");

    // no input is taken while a copy owns the history ram; this checks that none is pending after a byte with no action
    a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !pend_valid_reg || $past(action.kind == ACT_NONE) == 1'b0)
        else $error("input accepted during copy");

endmodule

`default_nettype wire
